### hdl/patch_merge_gather_address_gen_unit_assert.svh
// Assertion macros shared by the patch merge gather address generator modules.
`ifndef PATCH_MERGE_GATHER_ADDRESS_GEN_UNIT_ASSERT_SVH
`define PATCH_MERGE_GATHER_ADDRESS_GEN_UNIT_ASSERT_SVH

// Expression holds at every clock edge out of reset.
`define PMG_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pmg_pkg.sv
// Package: types, constants and helpers of the patch merge gather address generator.
package pmg_pkg;

    // Index fields are 25 bits wide
    localparam int IDX_W = 25;
    // Channel digit covers up to four channels
    localparam int CH_W  = 2;
    // Width of the side register write data
    localparam int SIDE_IN_W = 7;

    // Default geometry
    localparam int PATCH_DEF          = 16;
    localparam int MERGE_DEF          = 2;
    localparam int TIME_PATCH_DEF     = 2;
    localparam int FRAMES_DEF         = 2;
    localparam int CHANNELS_DEF       = 3;
    localparam int MAX_SIDE_UNITS_DEF = 64;

    // Queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef logic [IDX_W-1:0] idx_t;

    // Classified word from front to back: coordinates of one element
    typedef struct packed {
        idx_t            t_idx;
        idx_t            y_idx;
        idx_t            x_idx;
        logic [CH_W-1:0] chan;
        idx_t            dst;
        logic            last;
    } pmg_item_t;

    // Finished result word
    typedef struct packed {
        idx_t src;
        idx_t dst;
        logic last;
    } pmg_res_t;

    // Counter width for a digit that runs 0..n-1
    function automatic int cnt_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### hdl/pmg_fifo.sv
// Small register-based word queue with occupancy count.
`include "patch_merge_gather_address_gen_unit_assert.svh"

module pmg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `PMG_ASSERT_ALWAYS(a_fifo_count_bound, count_reg <= CNT_W'(DEPTH), "fifo overfilled")
    `PMG_ASSERT_IMP(a_fifo_no_overflow, push, !full || pop, "push into full fifo")
    `PMG_ASSERT_IMP(a_fifo_no_underflow, pop, !empty, "pop from empty fifo")

endmodule

### hdl/pmg_front.sv
// Front end: side register, element counters and classification of each word.
`include "patch_merge_gather_address_gen_unit_assert.svh"

module pmg_front #(
    parameter int PATCH          = pmg_pkg::PATCH_DEF,
    parameter int MERGE          = pmg_pkg::MERGE_DEF,
    parameter int TIME_PATCH     = pmg_pkg::TIME_PATCH_DEF,
    parameter int FRAMES         = pmg_pkg::FRAMES_DEF,
    parameter int CHANNELS       = pmg_pkg::CHANNELS_DEF,
    parameter int MAX_SIDE_UNITS = pmg_pkg::MAX_SIDE_UNITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               side_units_we,
    input  logic [pmg_pkg::SIDE_IN_W-1:0]      side_units,
    input  logic                               take,
    input  logic                               restart,
    output pmg_pkg::pmg_item_t                 item,
    output pmg_pkg::idx_t                      dim
);
    import pmg_pkg::*;

    localparam int GRID_T = ((FRAMES / TIME_PATCH) > 0) ? (FRAMES / TIME_PATCH) : 1;
    localparam int PC_W   = cnt_w(PATCH);
    localparam int TS_W   = cnt_w(TIME_PATCH);
    localparam int CC_W   = cnt_w(CHANNELS);
    localparam int MG_W   = cnt_w(MERGE);
    localparam int TG_W   = cnt_w(GRID_T);
    localparam int SIDE_W = $clog2(MAX_SIDE_UNITS+1);
    localparam int CMP_W  = 9;

    logic [PC_W-1:0]   pc_reg, pr_reg, pc, pr, pc_next, pr_next;
    logic [TS_W-1:0]   ts_reg, ts, ts_next;
    logic [CC_W-1:0]   cc_reg, cc, cc_next;
    logic [MG_W-1:0]   mc_reg, mr_reg, mc, mr, mc_next, mr_next;
    logic [SIDE_W-1:0] gc_reg, gr_reg, gc, gr, gc_next, gr_next;
    logic [TG_W-1:0]   tg_reg, tg, tg_next;
    idx_t              pos_reg, pos, pos_next;
    logic [SIDE_W-1:0] side_reg, side_next, side_top;
    idx_t              dim_reg, dim_next;
    logic [CMP_W-1:0]  side_x;
    logic              c1, c2, c3, c4, c5, c6, c7, c8, wrap;

    assign dim = dim_reg;

    // clamp the written side to 1..MAX_SIDE_UNITS
    always_comb
    begin
        side_x = CMP_W'(side_units);
        if (side_x == '0)
        begin
            side_next = SIDE_W'(1);
        end
        else if (side_x > CMP_W'(MAX_SIDE_UNITS))
        begin
            side_next = SIDE_W'(MAX_SIDE_UNITS);
        end
        else
        begin
            side_next = SIDE_W'(side_x);
        end
        dim_next = idx_t'(side_next) * idx_t'(MERGE * PATCH);
    end

    // current digits, cleared by restart, and the carry chain
    always_comb
    begin
        pc  = restart ? '0 : pc_reg;
        pr  = restart ? '0 : pr_reg;
        ts  = restart ? '0 : ts_reg;
        cc  = restart ? '0 : cc_reg;
        mc  = restart ? '0 : mc_reg;
        mr  = restart ? '0 : mr_reg;
        gc  = restart ? '0 : gc_reg;
        gr  = restart ? '0 : gr_reg;
        tg  = restart ? '0 : tg_reg;
        pos = restart ? '0 : pos_reg;
        side_top = side_reg - SIDE_W'(1);

        c1   = (pc == PC_W'(PATCH-1));
        c2   = c1 && (pr == PC_W'(PATCH-1));
        c3   = c2 && (ts == TS_W'(TIME_PATCH-1));
        c4   = c3 && (cc == CC_W'(CHANNELS-1));
        c5   = c4 && (mc == MG_W'(MERGE-1));
        c6   = c5 && (mr == MG_W'(MERGE-1));
        c7   = c6 && (gc == side_top);
        c8   = c7 && (gr == side_top);
        wrap = c8 && (tg == TG_W'(GRID_T-1));

        pc_next  = c1 ? '0 : pc + PC_W'(1);
        pr_next  = c1 ? (c2 ? '0 : pr + PC_W'(1)) : pr;
        ts_next  = c2 ? (c3 ? '0 : ts + TS_W'(1)) : ts;
        cc_next  = c3 ? (c4 ? '0 : cc + CC_W'(1)) : cc;
        mc_next  = c4 ? (c5 ? '0 : mc + MG_W'(1)) : mc;
        mr_next  = c5 ? (c6 ? '0 : mr + MG_W'(1)) : mr;
        gc_next  = c6 ? (c7 ? '0 : gc + SIDE_W'(1)) : gc;
        gr_next  = c7 ? (c8 ? '0 : gr + SIDE_W'(1)) : gr;
        tg_next  = c8 ? (wrap ? '0 : tg + TG_W'(1)) : tg;
        pos_next = wrap ? '0 : pos + idx_t'(1);
    end

    // classified word: frame, row, column and channel of this element, its destination and last flag
    always_comb
    begin
        item.t_idx = idx_t'(tg) * idx_t'(TIME_PATCH) + idx_t'(ts);
        item.y_idx = (idx_t'(gr) * idx_t'(MERGE) + idx_t'(mr)) * idx_t'(PATCH) + idx_t'(pr);
        item.x_idx = (idx_t'(gc) * idx_t'(MERGE) + idx_t'(mc)) * idx_t'(PATCH) + idx_t'(pc);
        item.chan  = CH_W'(cc);
        item.dst   = pos;
        item.last  = wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(1);
            dim_reg  <= idx_t'(MERGE * PATCH);
            pc_reg   <= '0;
            pr_reg   <= '0;
            ts_reg   <= '0;
            cc_reg   <= '0;
            mc_reg   <= '0;
            mr_reg   <= '0;
            gc_reg   <= '0;
            gr_reg   <= '0;
            tg_reg   <= '0;
            pos_reg  <= '0;
        end
        else if (side_units_we)
        begin
            // new side restarts the sequence
            side_reg <= side_next;
            dim_reg  <= dim_next;
            pc_reg   <= '0;
            pr_reg   <= '0;
            ts_reg   <= '0;
            cc_reg   <= '0;
            mc_reg   <= '0;
            mr_reg   <= '0;
            gc_reg   <= '0;
            gr_reg   <= '0;
            tg_reg   <= '0;
            pos_reg  <= '0;
        end
        else if (take)
        begin
            pc_reg  <= pc_next;
            pr_reg  <= pr_next;
            ts_reg  <= ts_next;
            cc_reg  <= cc_next;
            mc_reg  <= mc_next;
            mr_reg  <= mr_next;
            gc_reg  <= gc_next;
            gr_reg  <= gr_next;
            tg_reg  <= tg_next;
            pos_reg <= pos_next;
        end
    end

    `PMG_ASSERT_ALWAYS(a_front_side_range,
        (side_reg != '0) && (side_reg <= SIDE_W'(MAX_SIDE_UNITS)), "side register out of range")
    `PMG_ASSERT_ALWAYS(a_front_group_bound, (gc_reg < side_reg) && (gr_reg < side_reg),
        "group counter beyond side")
    `PMG_ASSERT_NEXT(a_front_wrap_pos, take && wrap && !side_units_we, pos_reg == '0,
        "position not cleared after last word")

endmodule

### hdl/pmg_back.sv
// Back end: two-stage multiply pipeline that turns coordinates into a source index.
`include "patch_merge_gather_address_gen_unit_assert.svh"

module pmg_back #(
    parameter int CHANNELS = pmg_pkg::CHANNELS_DEF,
    parameter int DEPTH    = pmg_pkg::OUT_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmg_pkg::pmg_item_t              item,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  pmg_pkg::idx_t                   dim,
    input  logic [$clog2(DEPTH+1)-1:0]      out_count,
    output logic                            res_push,
    output pmg_pkg::pmg_res_t               res
);
    import pmg_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    logic              v1_reg, v2_reg;
    idx_t              a1_reg, x1_reg, dst1_reg, b2_reg, dst2_reg;
    logic [CH_W-1:0]   c1_reg, c2_reg;
    logic              last1_reg, last2_reg;
    logic [CNT_W:0]    used;

    // space check: queued results plus words in flight
    assign used     = (CNT_W+1)'(out_count) + (CNT_W+1)'(v1_reg) + (CNT_W+1)'(v2_reg);
    assign item_pop = item_valid && (used < (CNT_W+1)'(DEPTH));

    // last step: scale by channel count and add channel digit
    assign res_push = v2_reg;
    assign res.src  = b2_reg * idx_t'(CHANNELS) + idx_t'(c2_reg);
    assign res.dst  = dst2_reg;
    assign res.last = last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= item_pop;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: frame * dim + row; stage 2: (..) * dim + column
    always_ff @(posedge clk)
    begin
        a1_reg    <= item.t_idx * dim + item.y_idx;
        x1_reg    <= item.x_idx;
        c1_reg    <= item.chan;
        dst1_reg  <= item.dst;
        last1_reg <= item.last;
        b2_reg    <= a1_reg * dim + x1_reg;
        c2_reg    <= c1_reg;
        dst2_reg  <= dst1_reg;
        last2_reg <= last1_reg;
    end

    `PMG_ASSERT_NEXT(a_back_stage_flow, v1_reg, v2_reg, "word lost between stages")
    `PMG_ASSERT_ALWAYS(a_back_credit, used <= (CNT_W+1)'(DEPTH), "result credit overrun")
    `PMG_ASSERT_IMP(a_back_pop_valid, item_pop, item_valid, "pop without queued word")

endmodule

### hdl/patch_merge_gather_address_gen_unit.sv
// Top level of the patch merge gather address generator.
//
// Emits, per input word, the source and destination element index of the next
// element of a patch-ordered, 2x2-merged view of a T x H x W x C frame stack.
// Input channel: a word (restart bit) is taken when push is high and full is
// low. restart=1 rewinds the sequence to element zero before this word emits.
// Result channel: while empty is low, src_index, dst_index and last show the
// oldest result; it is taken when pop is high. last marks the final element.
// side_units_we writes side_units (square side in 32-pixel units, 0 reads as
// 1, large values clamp) and rewinds the sequence; write only while idle.
// Accepted words pass through the middle queue, the two multiply stages and the
// result queue. Throughput: one word per cycle while no queue is full.
// Between front and back sits a 4-word queue; results wait in an 8-word queue.
// When the receiver stalls the result queue fills, the back end stops drawing
// words, the middle queue fills and full goes high.
// Reset clears all queues and counters and sets the side to one unit.
module patch_merge_gather_address_gen_unit #(
    parameter int PATCH          = pmg_pkg::PATCH_DEF,
    parameter int MERGE          = pmg_pkg::MERGE_DEF,
    parameter int TIME_PATCH     = pmg_pkg::TIME_PATCH_DEF,
    parameter int FRAMES         = pmg_pkg::FRAMES_DEF,
    parameter int CHANNELS       = pmg_pkg::CHANNELS_DEF,
    parameter int MAX_SIDE_UNITS = pmg_pkg::MAX_SIDE_UNITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          restart,
    output logic                          empty,
    input  logic                          pop,
    output pmg_pkg::idx_t                 src_index,
    output pmg_pkg::idx_t                 dst_index,
    output logic                          last,
    input  logic                          side_units_we,
    input  logic [pmg_pkg::SIDE_IN_W-1:0] side_units
);
    import pmg_pkg::*;

    localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);
    localparam int MID_CNT_W = $clog2(MID_DEPTH+1);

    pmg_item_t              front_item, back_item;
    pmg_res_t               back_res, out_res;
    idx_t                   dim;
    logic                   take, mid_empty, back_pop, res_push, out_pop;
    logic [OUT_CNT_W-1:0]   out_count;
    logic [MID_CNT_W-1:0]   mid_count;

    // input accept
    assign take = push && !full;

    pmg_front #(
        .PATCH          (PATCH),
        .MERGE          (MERGE),
        .TIME_PATCH     (TIME_PATCH),
        .FRAMES         (FRAMES),
        .CHANNELS       (CHANNELS),
        .MAX_SIDE_UNITS (MAX_SIDE_UNITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_units_we (side_units_we),
        .side_units    (side_units),
        .take          (take),
        .restart       (restart),
        .item          (front_item),
        .dim           (dim)
    );

    pmg_fifo #(
        .WIDTH ($bits(pmg_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_data (front_item),
        .full    (full),
        .pop     (back_pop),
        .rd_data (back_item),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    pmg_back #(
        .CHANNELS (CHANNELS),
        .DEPTH    (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (!mid_empty && (mid_count != '0)),
        .item_pop   (back_pop),
        .dim        (dim),
        .out_count  (out_count),
        .res_push   (res_push),
        .res        (back_res)
    );

    // result accept
    assign out_pop = pop && !empty;

    pmg_fifo #(
        .WIDTH ($bits(pmg_res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (),
        .pop     (out_pop),
        .rd_data (out_res),
        .empty   (empty),
        .count   (out_count)
    );

    assign src_index = out_res.src;
    assign dst_index = out_res.dst;
    assign last      = out_res.last;

endmodule

### bench/tb_top.sv
// Self-checking bench for the patch merge gather address generator.
`timescale 1ns / 100ps

module tb_top;

    localparam int PATCH      = pmg_pkg::PATCH_DEF;
    localparam int MERGE      = pmg_pkg::MERGE_DEF;
    localparam int TIME_PATCH = pmg_pkg::TIME_PATCH_DEF;
    localparam int FRAMES     = pmg_pkg::FRAMES_DEF;
    localparam int CHANNELS   = pmg_pkg::CHANNELS_DEF;
    localparam int MAX_SIDE   = pmg_pkg::MAX_SIDE_UNITS_DEF;
    localparam int TIME_GROUPS = (FRAMES / TIME_PATCH > 0) ? FRAMES / TIME_PATCH : 1;

    localparam int LONG_HOLD  = 400;
    localparam int STUCK_MAX  = 5000;

    // DUT connections
    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          push          = 1'b0;
    logic                          full;
    logic                          restart       = 1'b0;
    logic                          empty;
    logic                          pop           = 1'b0;
    pmg_pkg::idx_t                 src_index;
    pmg_pkg::idx_t                 dst_index;
    logic                          last;
    logic                          side_units_we = 1'b0;
    logic [pmg_pkg::SIDE_IN_W-1:0] side_units    = '0;

    // Predictor state: side register and the sequence counters
    bit [pmg_pkg::SIDE_IN_W-1:0] side_reg;
    bit [3:0]                    patch_col, patch_row;
    bit                          time_slice;
    bit [1:0]                    channel_count;
    bit                          merge_col, merge_row;
    bit [5:0]                    group_col, group_row;
    bit                          time_group;
    pmg_pkg::idx_t               out_pos;

    // Restart bits waiting to be offered, and addresses waiting to come out
    bit                 restart_pend_q[$];
    pmg_pkg::pmg_res_t  addr_expect_q[$];
    pmg_pkg::pmg_res_t  want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int fail_count     = 0;
    int stuck_cycles   = 0;

    patch_merge_gather_address_gen_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .restart      (restart),
        .empty        (empty),
        .pop          (pop),
        .src_index    (src_index),
        .dst_index    (dst_index),
        .last         (last),
        .side_units_we(side_units_we),
        .side_units   (side_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void rewind_counters();
        patch_col = '0; patch_row = '0; time_slice = '0; channel_count = '0;
        merge_col = '0; merge_row = '0; group_col = '0; group_row = '0;
        time_group = '0; out_pos = '0;
    endfunction

    // One digit of the odometer: returns the carry out
    function automatic bit wrap_digit(input int cur, input int lim, output int nxt);
        nxt = cur + 1;
        if (nxt >= lim)
        begin
            nxt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Addresses of the next element, then advance the counters
    function automatic pmg_pkg::pmg_res_t next_gather_addr(input bit rewind);
        pmg_pkg::pmg_res_t r;
        int     side;
        int     nv;
        longint dim, t, y, x, src;
        bit     carry;
        if (rewind)
            rewind_counters();
        side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
        dim  = longint'(side) * MERGE * PATCH;
        t    = longint'(time_group) * TIME_PATCH + time_slice;
        y    = (longint'(group_row) * MERGE + merge_row) * PATCH + patch_row;
        x    = (longint'(group_col) * MERGE + merge_col) * PATCH + patch_col;
        src  = ((t * dim + y) * dim + x) * CHANNELS + channel_count;
        r.src = src[pmg_pkg::IDX_W-1:0];
        r.dst = out_pos;

        // Fastest digit first
        carry = wrap_digit(int'(patch_col), PATCH, nv); patch_col = 4'(nv);
        if (carry) begin carry = wrap_digit(int'(patch_row), PATCH, nv); patch_row = 4'(nv); end
        if (carry)
        begin
            carry = wrap_digit(int'(time_slice), TIME_PATCH, nv); time_slice = 1'(nv);
        end
        if (carry)
        begin
            carry = wrap_digit(int'(channel_count), CHANNELS, nv); channel_count = 2'(nv);
        end
        if (carry) begin carry = wrap_digit(int'(merge_col), MERGE, nv); merge_col = 1'(nv); end
        if (carry) begin carry = wrap_digit(int'(merge_row), MERGE, nv); merge_row = 1'(nv); end
        if (carry) begin carry = wrap_digit(int'(group_col), side, nv); group_col = 6'(nv); end
        if (carry) begin carry = wrap_digit(int'(group_row), side, nv); group_row = 6'(nv); end
        if (carry)
        begin
            carry = wrap_digit(int'(time_group), TIME_GROUPS, nv); time_group = 1'(nv);
        end

        out_pos = carry ? '0 : out_pos + 1'b1;
        r.last  = carry;
        return r;
    endfunction

    // Driver: offers pending words, tracks side writes and accepted words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            restart <= 1'b0;
            side_reg = pmg_pkg::SIDE_IN_W'(1);
            rewind_counters();
        end
        else
        begin
            if (side_units_we)
            begin
                side_reg = side_units;
                rewind_counters();
            end
            if (push && !full)
                addr_expect_q.push_back(next_gather_addr(restart));
            // Hold the word while full blocks it
            if (!(push && full))
            begin
                if (restart_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push    <= 1'b1;
                    restart <= restart_pend_q.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: checks each popped word, drives pop with stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (addr_expect_q.size() == 0)
                begin
                    $error("unexpected word: src_index %0d dst_index %0d last %0b",
                           src_index, dst_index, last);
                    fail_count++;
                end
                else
                begin
                    want = addr_expect_q.pop_front();
                    if (src_index !== want.src)
                    begin
                        $error("src_index mismatch: expected %0d, got %0d", want.src, src_index);
                        fail_count++;
                    end
                    if (dst_index !== want.dst)
                    begin
                        $error("dst_index mismatch: expected %0d, got %0d", want.dst, dst_index);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last mismatch: expected %0b, got %0b", want.last, last);
                        fail_count++;
                    end
                end
            end
            // Long hold-off on request, else random stalls
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: no progress while work is outstanding
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty)
            || (restart_pend_q.size() == 0 && addr_expect_q.size() == 0 && !push))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (restart_pend_q.size() != 0 || push || addr_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // Side write while the block is idle
    task automatic write_side(input bit [pmg_pkg::SIDE_IN_W-1:0] v);
        @(posedge clk);
        side_units_we <= 1'b1;
        side_units    <= v;
        @(posedge clk);
        side_units_we <= 1'b0;
    endtask

    // Random run: mostly long uninterrupted sequences, rare restarts
    task automatic run_words(input int count, input int restart_pm,
                             input int idle_pct, input int stall_pct);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            restart_pend_q.push_back($urandom_range(999) < restart_pm);
        wait_drained();
    endtask

    initial
    begin
        static bit directed_a[12] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: restart at zero, restart mid-run, back-to-back restarts
        @(negedge clk);
        foreach (directed_a[i])
            restart_pend_q.push_back(directed_a[i]);
        wait_drained();

        // Side of zero reads as one; write also rewinds mid-sequence
        write_side(7'd0);
        run_words(5, 0, 0, 0);
        // Above the maximum saturates
        write_side(7'd127);
        run_words(5, 0, 0, 0);
        write_side(7'd65);
        run_words(3, 0, 0, 0);

        // Receiver holds off long while the sender keeps offering
        write_side(7'd64);
        @(negedge clk);
        hold_requests++;
        run_words(300, 3, 0, 0);

        // Side one with both sides idling
        write_side(7'd1);
        run_words(400, 0, 17, 17);

        // Side two, then random sides, across the idling modes
        write_side(7'd2);
        run_words(230, 8, 0, 0);
        write_side(7'($urandom_range(0, 127)));
        run_words(230, 8, 45, 0);
        write_side(7'($urandom_range(1, 64)));
        run_words(230, 8, 0, 45);
        write_side(7'($urandom_range(0, 127)));
        run_words(230, 8, 17, 17);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
